### rtl/dduq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dduq_pkg
// shared types for the deduplicating deque: request kinds, result codes,
// controller states and the command and status groups between the units
// ---------------------------------------------------------------------------
package dduq_pkg;

  // request kind carried on the input tuser
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_SEARCH     = 3'd2,
    KIND_DUMP_FWD   = 3'd3,
    KIND_DUMP_REV   = 3'd4
  } kind_e;

  // result code carried on the output tuser
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ELEMENT   = 3'd5,
    ST_EMPTY     = 3'd6
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DUMP,
    S_WRITE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    cap;      // capture request, restart walk
    logic    issue;    // read next element, advance walk index
    logic    consume;  // pending read data has been used
    logic    load;     // load result word into output register
    status_e res;      // result code of loaded word
    logic    wr;       // insert captured value
  } dduq_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e kind;      // captured request kind
    logic  hit;       // pending read equals captured value
    logic  more;      // elements left to read
    logic  rd_pend;   // read data waiting
    logic  full;      // store is full
    logic  cnt_zero;  // store is empty
    logic  out_free;  // output register can take a word
  } dduq_sts_t;

endpackage

### rtl/dedup_deque_with_search_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dedup_deque_with_search_unit
// deduplicating double-ended queue of signed 32-bit values with search
// ---------------------------------------------------------------------------
// Keeps up to DEPTH distinct values in a circular slot ram. Push-front and
// push-back walk the stored values first and answer duplicate on a match,
// full when the store is full, else inserted. Search answers found with the
// position from the front, or not found. Dumps stream every element front to
// back or back to front with tlast on the final word; an empty store dumps
// one empty word. One request is worked at a time. After the accepting cycle
// a push or search stays busy while it walks the stored values (a push that
// inserts also in a write state) and a dump while it streams them, plus any
// output stall. The single read port of the slot ram sets the pace of the
// walk: it delivers one element per cycle, held during a dump while the
// output stalls, each in the cycle after its address, and a scan decides only
// after its last element has been compared. The finished word sits in an
// output register, so the next request is taken while it waits.
// ---------------------------------------------------------------------------
module dedup_deque_with_search_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] item_value, [35:32] position
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);

  dduq_pkg::dduq_cmd_t cmd;
  dduq_pkg::dduq_sts_t sts;
  logic [31:0]         out_value;
  logic [3:0]          out_pos;

  // sequencer
  dduq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store and result path
  dduq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_kind_i    (s_axis_tuser),
    .in_value_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_value_o  (out_value),
    .out_pos_o    (out_pos),
    .out_last_o   (m_axis_tlast)
  );

  // pack output word
  assign m_axis_tdata = {4'b0000, out_pos, out_value};

endmodule

### rtl/dduq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dduq_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module dduq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dduq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dduq_ctrl
// request sequencer: accepts a word, walks the store for scans and dumps,
// decides the result and triggers insertion
// ---------------------------------------------------------------------------
module dduq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [2:0]         in_kind_i,
  output logic               in_ready_o,
  input  dduq_pkg::dduq_sts_t sts_i,
  output dduq_pkg::dduq_cmd_t cmd_o
);

  dduq_pkg::state_e state_q, state_d;
  logic             in_acc;
  logic             is_push;
  logic             miss_done;

  assign in_ready_o = (state_q == dduq_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_push    = (sts_i.kind == dduq_pkg::KIND_PUSH_FRONT) ||
                      (sts_i.kind == dduq_pkg::KIND_PUSH_BACK);
  assign miss_done  = !sts_i.more && !sts_i.rd_pend;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dduq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dduq_pkg::S_IDLE: begin
        if (in_acc) begin
          case (dduq_pkg::kind_e'(in_kind_i))
            dduq_pkg::KIND_PUSH_FRONT,
            dduq_pkg::KIND_PUSH_BACK,
            dduq_pkg::KIND_SEARCH:   state_d = dduq_pkg::S_SCAN;
            dduq_pkg::KIND_DUMP_FWD,
            dduq_pkg::KIND_DUMP_REV: state_d = dduq_pkg::S_DUMP;
            default:                 state_d = dduq_pkg::S_IDLE;
          endcase
        end
      end
      dduq_pkg::S_SCAN: begin
        if (sts_i.hit) begin
          if (sts_i.out_free) state_d = dduq_pkg::S_IDLE;
        end else if (miss_done) begin
          if (is_push && !sts_i.full) begin
            state_d = dduq_pkg::S_WRITE;
          end else if (sts_i.out_free) begin
            state_d = dduq_pkg::S_IDLE;
          end
        end
      end
      dduq_pkg::S_DUMP: begin
        if (sts_i.cnt_zero) begin
          if (sts_i.out_free) state_d = dduq_pkg::S_IDLE;
        end else if (!sts_i.more) begin
          if (!sts_i.rd_pend || sts_i.out_free) state_d = dduq_pkg::S_IDLE;
        end
      end
      dduq_pkg::S_WRITE: begin
        if (sts_i.out_free) state_d = dduq_pkg::S_IDLE;
      end
      default: state_d = dduq_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o     = '0;
    cmd_o.res = dduq_pkg::ST_INSERTED;
    case (state_q)
      dduq_pkg::S_IDLE: begin
        cmd_o.cap = in_acc;
      end
      dduq_pkg::S_SCAN: begin
        if (sts_i.hit) begin
          // equal value found, walk stops here
          cmd_o.load = sts_i.out_free;
          cmd_o.res  = is_push ? dduq_pkg::ST_DUPLICATE : dduq_pkg::ST_FOUND;
        end else if (miss_done) begin
          if (!is_push) begin
            cmd_o.load = sts_i.out_free;
            cmd_o.res  = dduq_pkg::ST_NOT_FOUND;
          end else if (sts_i.full) begin
            cmd_o.load = sts_i.out_free;
            cmd_o.res  = dduq_pkg::ST_FULL;
          end
        end else begin
          // keep the read pipe full, drop mismatches
          cmd_o.issue   = sts_i.more;
          cmd_o.consume = sts_i.rd_pend;
        end
      end
      dduq_pkg::S_DUMP: begin
        if (sts_i.cnt_zero) begin
          cmd_o.load = sts_i.out_free;
          cmd_o.res  = dduq_pkg::ST_EMPTY;
        end else if (!sts_i.rd_pend || sts_i.out_free) begin
          cmd_o.load    = sts_i.rd_pend;
          cmd_o.consume = sts_i.rd_pend;
          cmd_o.res     = dduq_pkg::ST_ELEMENT;
          cmd_o.issue   = sts_i.more;
        end
      end
      dduq_pkg::S_WRITE: begin
        cmd_o.wr   = sts_i.out_free;
        cmd_o.load = sts_i.out_free;
        cmd_o.res  = dduq_pkg::ST_INSERTED;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### rtl/dduq_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dduq_dpath
// deque datapath: front pointer, element count, walk index, slot ram,
// compare and output register
// ---------------------------------------------------------------------------
module dduq_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          in_kind_i,
  input  logic [31:0]         in_value_i,
  input  dduq_pkg::dduq_cmd_t cmd_i,
  output dduq_pkg::dduq_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          out_status_o,
  output logic [31:0]         out_value_o,
  output logic [3:0]          out_pos_o,
  output logic                out_last_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dduq_pkg::kind_e kind_q;
  logic [31:0]     value_q;
  logic [AW-1:0]   front_q, front_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   rd_pos_q, rd_pos_d;
  logic            rd_last_q, rd_last_d;
  logic            rd_pend_q, rd_pend_d;
  logic [AW-1:0]   logic_idx;
  logic [AW:0]     rd_sum;
  logic [AW-1:0]   rd_addr;
  logic [AW:0]     wb_sum;
  logic [AW-1:0]   front_dec;
  logic [AW-1:0]   wr_addr;
  logic [31:0]     rd_data;
  logic            out_vld_q, out_vld_d;
  logic [2:0]      out_st_q;
  logic [31:0]     out_val_q;
  logic [3:0]      out_pos_q;
  logic            out_last_q;
  logic            is_rev;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      front_q   <= front_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_pend_q <= rd_pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  // request and walk payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q  <= dduq_pkg::kind_e'(in_kind_i);
      value_q <= in_value_i;
    end
    rd_pos_q  <= rd_pos_d;
    rd_last_q <= rd_last_d;
  end

  // logical index of next read, back to front for reverse dump
  assign is_rev    = (kind_q == dduq_pkg::KIND_DUMP_REV);
  assign logic_idx = is_rev ? AW'(count_q - idx_q - CW'(1)) : AW'(idx_q);

  // slot of a logical index, wrap by one compare and subtract
  assign rd_sum  = {1'b0, front_q} + {1'b0, logic_idx};
  assign rd_addr = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH))
                                              : AW'(rd_sum);

  // insertion slot
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign wb_sum    = {1'b0, front_q} + {1'b0, AW'(count_q)};
  always_comb begin
    if (kind_q == dduq_pkg::KIND_PUSH_FRONT) begin
      wr_addr = front_dec;
    end else if (wb_sum >= (AW+1)'(DEPTH)) begin
      wr_addr = AW'(wb_sum - (AW+1)'(DEPTH));
    end else begin
      wr_addr = AW'(wb_sum);
    end
  end

  // walk and pointer updates
  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rd_pos_d  = rd_pos_q;
    rd_last_d = rd_last_q;
    rd_pend_d = rd_pend_q;
    if (cmd_i.cap) begin
      idx_d     = '0;
      rd_pend_d = 1'b0;
    end else begin
      if (cmd_i.consume) rd_pend_d = 1'b0;
      if (cmd_i.issue) begin
        idx_d     = idx_q + CW'(1);
        rd_pos_d  = logic_idx;
        rd_last_d = (idx_q + CW'(1) == count_q);
        rd_pend_d = 1'b1;
      end
    end
    if (cmd_i.wr) begin
      count_d = count_q + CW'(1);
      if (kind_q == dduq_pkg::KIND_PUSH_FRONT) front_d = front_dec;
    end
  end

  dduq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (wr_addr),
    .wdata_i (value_q),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // status to controller
  assign sts_o.kind     = kind_q;
  assign sts_o.hit      = rd_pend_q && (rd_data == value_q);
  assign sts_o.more     = (idx_q < count_q);
  assign sts_o.rd_pend  = rd_pend_q;
  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  // output register
  assign out_vld_d = cmd_i.load ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_st_q <= cmd_i.res;
      case (cmd_i.res)
        dduq_pkg::ST_ELEMENT: begin
          out_val_q  <= rd_data;
          out_pos_q  <= 4'(rd_pos_q);
          out_last_q <= rd_last_q;
        end
        dduq_pkg::ST_FOUND: begin
          out_val_q  <= value_q;
          out_pos_q  <= 4'(rd_pos_q);
          out_last_q <= 1'b1;
        end
        dduq_pkg::ST_EMPTY: begin
          out_val_q  <= '0;
          out_pos_q  <= '0;
          out_last_q <= 1'b1;
        end
        default: begin
          out_val_q  <= value_q;
          out_pos_q  <= '0;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_st_q;
  assign out_value_o  = out_val_q;
  assign out_pos_o    = out_pos_q;
  assign out_last_o   = out_last_q;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for dedup_deque_with_search_unit
// ---------------------------------------------------------------------------
// Requests go in on the input stream and every result word is compared with
// a behavioral deque kept in a small scoreboard class. A short directed
// sequence covers the empty dumps, extreme values, duplicates and the
// unused kinds. Random requests then fill the store slowly, so inserts,
// full answers, searches and dumps show up both before and after the store
// is full. Both stream sides insert random gaps, with bursts that have none.
// ---------------------------------------------------------------------------
module tb;

  localparam int DEPTH        = 16;
  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 443;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 40;

  // one result word with its fields
  typedef struct {
    dduq_pkg::status_e status;
    logic [31:0]       item_value;
    logic [3:0]        position;
    logic              last;
  } result_word_t;

  // behavioral deque and the words it still awaits
  class deque_scoreboard;
    logic [31:0]  slots [DEPTH];
    int unsigned  front_slot;
    int unsigned  fill;
    result_word_t awaited_words [$];
    int           mismatches;
    int           requests;
    int           words_checked;
    int           status_seen [8];

    function new();
      front_slot    = 0;
      fill          = 0;
      mismatches    = 0;
      requests      = 0;
      words_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return awaited_words.size();
    endfunction

    // index from the front of a stored value, or -1
    function int locate(logic [31:0] v);
      for (int i = 0; i < fill; i++)
        if (slots[(front_slot + i) % DEPTH] == v) return i;
      return -1;
    endfunction

    function logic [31:0] random_member();
      return slots[(front_slot + $urandom_range(0, fill - 1)) % DEPTH];
    endfunction

    function void await_word(dduq_pkg::status_e st, logic [31:0] v, int pos,
                             logic last);
      result_word_t w;
      w.status     = st;
      w.item_value = v;
      w.position   = 4'(pos);
      w.last       = last;
      awaited_words.push_back(w);
    endfunction

    // accepted request: update the deque and queue its result words
    function void note_request(logic [2:0] kind, logic [31:0] v);
      int hit;
      int idx;
      requests++;
      hit = locate(v);
      case (kind)
        dduq_pkg::KIND_PUSH_FRONT, dduq_pkg::KIND_PUSH_BACK: begin
          // duplicate check comes before the full check
          if (hit >= 0) begin
            await_word(dduq_pkg::ST_DUPLICATE, v, 0, 1'b1);
          end else if (fill >= DEPTH) begin
            await_word(dduq_pkg::ST_FULL, v, 0, 1'b1);
          end else begin
            if (kind == dduq_pkg::KIND_PUSH_FRONT) begin
              front_slot        = (front_slot + DEPTH - 1) % DEPTH;
              slots[front_slot] = v;
            end else begin
              slots[(front_slot + fill) % DEPTH] = v;
            end
            fill++;
            await_word(dduq_pkg::ST_INSERTED, v, 0, 1'b1);
          end
        end
        dduq_pkg::KIND_SEARCH: begin
          if (hit >= 0) await_word(dduq_pkg::ST_FOUND, v, hit, 1'b1);
          else          await_word(dduq_pkg::ST_NOT_FOUND, v, 0, 1'b1);
        end
        dduq_pkg::KIND_DUMP_FWD, dduq_pkg::KIND_DUMP_REV: begin
          if (fill == 0) begin
            await_word(dduq_pkg::ST_EMPTY, 32'd0, 0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) begin
              idx = (kind == dduq_pkg::KIND_DUMP_FWD) ? i : fill - 1 - i;
              await_word(dduq_pkg::ST_ELEMENT, slots[(front_slot + idx) % DEPTH],
                         idx, i == fill - 1);
            end
          end
        end
        default: ;  // unused kinds give no word
      endcase
    endfunction

    // accepted result word: compare with the oldest awaited one
    function void check_word(logic [2:0] st, logic [31:0] v, logic [3:0] pos,
                             logic last);
      result_word_t w;
      words_checked++;
      status_seen[st]++;
      if (awaited_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected word status %0d value %h pos %0d last %0d",
                   st, v, pos, last);
        return;
      end
      w = awaited_words.pop_front();
      if (st !== w.status || v !== w.item_value || pos !== w.position ||
          last !== w.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at word %0d: expected status %0d value %h pos %0d last %0d",
                   words_checked, w.status, w.item_value, w.position, w.last);
          $display("                     actual   status %0d value %h pos %0d last %0d",
                   st, v, pos, last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value
  logic [2:0]  s_axis_tuser;   // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] item_value, [35:32] position
  logic [2:0]  m_axis_tuser;   // [2:0] status
  logic        m_axis_tlast;

  deque_scoreboard sb;
  bit              burst;
  int              cycle_count = 0;

  dedup_deque_with_search_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still awaited",
               cycle_count, sb.pending());
      $display("tb: errors");
      $finish;
    end
  end

  // value mix with the extremes showing up often
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // one request word, held until accepted
  task automatic send_item(input logic [2:0] kind, input logic [31:0] value);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(kind, value);
  endtask

  // stop sending until every awaited word is out
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls after each word, none in bursts
  initial begin
    int rx_hold;
    rx_hold       = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[35:32],
                      m_axis_tlast);
        rx_hold = burst ? 0 : $urandom_range(0, 10);
      end
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // request side and end of run
  initial begin
    int          counted;
    int          n;
    int          roll;
    logic [2:0]  kind;
    logic [31:0] value;
    sb            = new();
    burst         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, extremes, duplicates, unused kinds
    send_item(dduq_pkg::KIND_DUMP_FWD, 32'h1234_5678);
    send_item(dduq_pkg::KIND_DUMP_REV, 32'hffff_ffff);
    send_item(dduq_pkg::KIND_SEARCH, 32'h0000_0005);
    send_item(dduq_pkg::KIND_PUSH_BACK, 32'h7fff_ffff);
    send_item(dduq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
    send_item(dduq_pkg::KIND_PUSH_BACK, 32'h0000_0000);
    send_item(dduq_pkg::KIND_PUSH_FRONT, 32'hffff_ffff);
    send_item(dduq_pkg::KIND_PUSH_BACK, 32'h0000_0000);
    send_item(dduq_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff);
    send_item(dduq_pkg::KIND_SEARCH, 32'h8000_0000);
    send_item(dduq_pkg::KIND_SEARCH, 32'hffff_ffff);
    send_item(dduq_pkg::KIND_SEARCH, 32'h0000_0001);
    send_item(3'd5, 32'h0000_0000);
    send_item(3'd6, 32'h7fff_ffff);
    send_item(3'd7, 32'hffff_ffff);
    send_item(dduq_pkg::KIND_DUMP_FWD, 32'h0000_0000);
    send_item(dduq_pkg::KIND_DUMP_REV, 32'h8000_0000);
    hold_until_drained();

    // random: rare fresh inserts so the store fills partway through
    counted = 0;
    n       = 0;
    while (counted < RANDOM_ITEMS) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      n++;
      roll = $urandom_range(0, 99);
      counted++;
      if (roll < 10) begin
        kind  = $urandom_range(0, 1) ? dduq_pkg::KIND_PUSH_BACK
                                     : dduq_pkg::KIND_PUSH_FRONT;
        value = pick_value();
      end else if (roll < 32) begin
        kind  = $urandom_range(0, 1) ? dduq_pkg::KIND_PUSH_BACK
                                     : dduq_pkg::KIND_PUSH_FRONT;
        value = (sb.fill > 0) ? sb.random_member() : pick_value();
      end else if (roll < 45) begin
        kind  = dduq_pkg::KIND_SEARCH;
        value = (sb.fill > 0) ? sb.random_member() : pick_value();
      end else if (roll < 58) begin
        kind  = dduq_pkg::KIND_SEARCH;
        value = pick_value();
      end else if (roll < 92) begin
        kind  = $urandom_range(0, 1) ? dduq_pkg::KIND_DUMP_REV
                                     : dduq_pkg::KIND_DUMP_FWD;
        value = $urandom;
      end else begin
        // unused kinds, no word expected
        kind  = 3'($urandom_range(5, 7));
        value = $urandom;
      end
      send_item(kind, value);
    end
    burst = 1'b0;
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d requests, %0d result words, %0d stored at the end",
             sb.requests, sb.words_checked, sb.fill);
    $display("summary: ins %0d dup %0d full %0d found %0d miss %0d elem %0d empty %0d",
             sb.status_seen[dduq_pkg::ST_INSERTED], sb.status_seen[dduq_pkg::ST_DUPLICATE],
             sb.status_seen[dduq_pkg::ST_FULL], sb.status_seen[dduq_pkg::ST_FOUND],
             sb.status_seen[dduq_pkg::ST_NOT_FOUND], sb.status_seen[dduq_pkg::ST_ELEMENT],
             sb.status_seen[dduq_pkg::ST_EMPTY]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("%0d mismatches, %0d words never seen", sb.mismatches, sb.pending());
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dduq_pkg.sv
rtl/dduq_ram.sv
rtl/dduq_ctrl.sv
rtl/dduq_dpath.sv
rtl/dedup_deque_with_search_unit.sv
test/tb.sv
